// ----- src/assert_macros.svh -----
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PDTF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define PDTF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/pdtf_pkg.sv -----
// types and constants of the pd tape follower
package pdtf_pkg;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int THRESH_W    = 10;
	localparam int GAIN_W      = 8;
	localparam int BASE_W      = 9;
	localparam int SCALE_W     = 10;
	localparam int DRIVE_W     = 9;
	localparam int ERR_W       = 4;
	localparam int QUO_W       = DRIVE_W - 1;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	typedef logic signed [DRIVE_W-1:0] drive_t;
	typedef logic signed [ERR_W-1:0]   err_t;

	localparam logic [CFG_INDEX_W-1:0] REG_WHITE_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_POWER_SCALE     = 3'd4;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd512;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 10'd256;

	localparam err_t ERR_ZERO     = 4'sd0;
	localparam err_t ERR_POS_ONE  = 4'sd1;
	localparam err_t ERR_NEG_ONE  = -4'sd1;
	localparam err_t ERR_POS_FIVE = 4'sd5;
	localparam err_t ERR_NEG_FIVE = -4'sd5;

	localparam logic [QUO_W-1:0] DRIVE_LIMIT     = 8'd255;
	localparam drive_t           DRIVE_MOST_NEG  = -9'sd256;

endpackage

// ----- src/pdtf_if.sv -----
// sensor and motor channel interfaces
interface pdtf_in_if
	import pdtf_pkg::*;
	#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [SAMPLE_BITS-1:0] right_sample;
	logic [SAMPLE_BITS-1:0] left_sample;

	modport source (output valid, op, right_sample, left_sample, input ready);
	modport sink (input valid, op, right_sample, left_sample, output ready);
endinterface

interface pdtf_out_if
	import pdtf_pkg::*;
	;
	logic   valid;
	logic   ready;
	drive_t right_drive;
	drive_t left_drive;
	err_t   track_error;
	logic   is_restart;

	modport source (output valid, right_drive, left_drive, track_error, is_restart, input ready);
	modport sink (input valid, right_drive, left_drive, track_error, is_restart, output ready);
endinterface

// ----- src/pd_tape_follower.sv -----
// pd tape follower top level: sensor classification, pd gain and serial drive divider
// One sensor beat is taken at a time and classified in the cycle it is accepted. A
// control step runs from acceptance to the result register through the gain products,
// then for each drive the scaling, run-length multiply and magnitude states and the
// shift-subtract divider, which after a first overflow check yields one quotient bit
// per cycle and is run once for the right drive and once for the left, then the load
// of the result register, which waits while the previous result is not yet taken.
// A restart skips straight to that load. A new sensor beat is accepted while the
// previous result still waits in the output register. Configuration writes are
// registered and are taken at any time.
module pd_tape_follower
	import pdtf_pkg::*;
	#(
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
	) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	pdtf_in_if.sink                sensor,
	pdtf_out_if.source             motor
	);

	localparam int CMP_W     = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
	localparam int DELTA_W   = ERR_W + 1;
	localparam int KPE_W     = 12;
	localparam int A_W       = 12;
	localparam int KDD_W     = 13;
	localparam int P_W       = 22;
	localparam int Q_W       = 23;
	localparam int T_W       = Q_W + COUNT_BITS;
	localparam int X_W       = T_W - 8;
	localparam int DV_W      = COUNT_BITS + 8;
	localparam int DIV_STEPS = QUO_W + 1;
	localparam int STEP_W    = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_SCALE,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [THRESH_W-1:0]       thresh_q;
	logic [GAIN_W-1:0]         kp_q;
	logic [GAIN_W-1:0]         kd_q;
	logic signed [BASE_W-1:0]  base_q;
	logic [SCALE_W-1:0]        ps_q;

	err_t                      prior_q;
	err_t                      pde_q;
	logic                      last_pos_q;
	logic [COUNT_BITS-1:0]     run_q;

	err_t                      err_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [COUNT_BITS-1:0]     n_q;
	logic                      restart_q;
	logic                      side_q;
	logic signed [KPE_W-1:0]   kpe_q;
	logic signed [KDD_W-1:0]   kdd_q;
	logic signed [P_W-1:0]     p_q;
	logic signed [Q_W-1:0]     qq_q;
	logic signed [T_W-1:0]     t_q;
	logic [X_W-1:0]            x_q;
	logic [DV_W-1:0]           dv_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [QUO_W-1:0]          quo_q;
	logic [STEP_W-1:0]         step_q;
	drive_t                    rdrive_q;
	drive_t                    ldrive_q;

	logic                      mv_q;
	drive_t                    mright_q;
	drive_t                    mleft_q;
	err_t                      merr_q;
	logic                      mrestart_q;

	logic                      right_white;
	logic                      left_white;
	logic                      both_on;
	err_t                      err_c;
	err_t                      pde_use;
	logic signed [DELTA_W-1:0] delta_c;
	logic                      changed;
	logic [COUNT_BITS-1:0]     n_c;
	logic signed [A_W-1:0]     base_ext;
	logic signed [A_W-1:0]     a_c;
	logic [T_W-1:0]            mag_c;
	logic                      ge_c;
	logic [QUO_W-1:0]          quo_nxt;
	logic [QUO_W-1:0]          qmag_c;
	drive_t                    drive_c;

	assign sensor.ready      = (state_q == ST_IDLE);
	assign motor.valid       = mv_q;
	assign motor.right_drive = mright_q;
	assign motor.left_drive  = mleft_q;
	assign motor.track_error = merr_q;
	assign motor.is_restart  = mrestart_q;

	// sensor classification
	always_comb begin
		right_white = CMP_W'(sensor.right_sample) < CMP_W'(thresh_q);
		left_white  = CMP_W'(sensor.left_sample) < CMP_W'(thresh_q);
		both_on     = 1'b0;
		unique case ({right_white, left_white})
			2'b00: begin
				err_c   = ERR_ZERO;
				both_on = 1'b1;
			end
			2'b01: err_c = ERR_NEG_ONE;
			2'b10: err_c = ERR_POS_ONE;
			default: err_c = last_pos_q ? ERR_POS_FIVE : ERR_NEG_FIVE;
		endcase
		pde_use = both_on ? ERR_ZERO : pde_q;
		delta_c = DELTA_W'(err_c) - DELTA_W'(pde_use);
		changed = (err_c != prior_q);
		n_c     = (run_q == '0) ? COUNT_BITS'(1) : run_q;
	end

	// drive datapath
	always_comb begin
		base_ext = A_W'(base_q);
		a_c      = (side_q ? -base_ext : base_ext) + A_W'(kpe_q);
		mag_c    = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
		ge_c     = x_q >= X_W'(dv_q);
		quo_nxt  = {quo_q[QUO_W-2:0], ge_c};
		qmag_c   = sat_q ? DRIVE_LIMIT : quo_nxt;
		drive_c  = neg_q ? -drive_t'({1'b0, qmag_c}) : drive_t'({1'b0, qmag_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			kp_q     <= '0;
			kd_q     <= '0;
			base_q   <= '0;
			ps_q     <= SCALE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_WHITE_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				REG_PROP_GAIN:       kp_q     <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:      kd_q     <= cfg_data[GAIN_W-1:0];
				REG_BASE_SPEED:      base_q   <= $signed(cfg_data[BASE_W-1:0]);
				REG_POWER_SCALE:     ps_q     <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prior_q    <= ERR_ZERO;
			pde_q      <= ERR_ZERO;
			last_pos_q <= 1'b0;
			run_q      <= '0;
			err_q      <= ERR_ZERO;
			delta_q    <= '0;
			n_q        <= '0;
			restart_q  <= 1'b0;
			side_q     <= 1'b0;
			kpe_q      <= '0;
			kdd_q      <= '0;
			p_q        <= '0;
			qq_q       <= '0;
			t_q        <= '0;
			x_q        <= '0;
			dv_q       <= '0;
			neg_q      <= 1'b0;
			sat_q      <= 1'b0;
			quo_q      <= '0;
			step_q     <= '0;
			rdrive_q   <= '0;
			ldrive_q   <= '0;
			mv_q       <= 1'b0;
			mright_q   <= '0;
			mleft_q    <= '0;
			merr_q     <= ERR_ZERO;
			mrestart_q <= 1'b0;
		end else begin
			if (mv_q && motor.ready && state_q != ST_DONE) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sensor.valid) begin
						if (sensor.op) begin
							prior_q    <= ERR_ZERO;
							pde_q      <= ERR_ZERO;
							last_pos_q <= 1'b0;
							run_q      <= '0;
							restart_q  <= 1'b1;
							state_q    <= ST_DONE;
						end else begin
							err_q     <= err_c;
							delta_q   <= delta_c;
							n_q       <= n_c;
							restart_q <= 1'b0;
							side_q    <= 1'b0;
							if ({right_white, left_white} == 2'b01) begin
								last_pos_q <= 1'b0;
							end else if ({right_white, left_white} == 2'b10) begin
								last_pos_q <= 1'b1;
							end
							pde_q   <= changed ? prior_q : pde_use;
							prior_q <= err_c;
							if (changed) begin
								run_q <= COUNT_BITS'(1);
							end else if (run_q != '1) begin
								run_q <= run_q + COUNT_BITS'(1);
							end
							state_q <= ST_GAIN;
						end
					end
				end
				ST_GAIN: begin
					kpe_q   <= KPE_W'($signed({1'b0, kp_q})) * KPE_W'(err_q);
					kdd_q   <= KDD_W'($signed({1'b0, kd_q})) * KDD_W'(delta_q);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					p_q     <= P_W'($signed({1'b0, ps_q})) * P_W'(a_c);
					qq_q    <= Q_W'($signed({1'b0, ps_q})) * Q_W'(kdd_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					t_q     <= T_W'(p_q) * T_W'($signed({1'b0, n_q})) + T_W'(qq_q);
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					neg_q   <= t_q[T_W-1];
					x_q     <= mag_c[T_W-1:8];
					dv_q    <= {n_q, 8'b0};
					sat_q   <= 1'b0;
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// first step only checks for overflow past the drive limit
					if (step_q == '0) begin
						sat_q <= ge_c;
					end else begin
						if (ge_c) begin
							x_q <= x_q - X_W'(dv_q);
						end
						quo_q <= quo_nxt;
					end
					dv_q   <= dv_q >> 1;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						if (!side_q) begin
							rdrive_q <= drive_c;
							side_q   <= 1'b1;
							state_q  <= ST_SCALE;
						end else begin
							ldrive_q <= drive_c;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!mv_q || motor.ready) begin
						mv_q       <= 1'b1;
						mright_q   <= restart_q ? drive_t'(0) : rdrive_q;
						mleft_q    <= restart_q ? drive_t'(0) : ldrive_q;
						merr_q     <= restart_q ? ERR_ZERO : err_q;
						mrestart_q <= restart_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/pdtf_checker.sv -----
// port checker for the pd tape follower, bound to the top level
`include "assert_macros.svh"

module pdtf_checker
	import pdtf_pkg::*;
	(
	input logic   clk,
	input logic   arst_n,
	input logic   motor_valid,
	input logic   motor_ready,
	input drive_t motor_right_drive,
	input drive_t motor_left_drive,
	input err_t   motor_track_error,
	input logic   motor_is_restart
	);

	`PDTF_ASSERT(a_valid_holds, clk, arst_n, motor_valid && !motor_ready |=> motor_valid, "result beat dropped before taken")
	`PDTF_ASSERT(a_beat_stable, clk, arst_n, motor_valid && !motor_ready |=> $stable(motor_right_drive) && $stable(motor_left_drive) && $stable(motor_track_error) && $stable(motor_is_restart), "stalled result beat changed")
	`PDTF_ASSERT(a_restart_zero, clk, arst_n, motor_valid && motor_is_restart |-> motor_right_drive == drive_t'(0) && motor_left_drive == drive_t'(0) && motor_track_error == ERR_ZERO, "restart beat carries non-zero fields")
	`PDTF_ASSERT(a_error_legal, clk, arst_n, motor_valid |-> motor_track_error == ERR_ZERO || motor_track_error == ERR_POS_ONE || motor_track_error == ERR_NEG_ONE || motor_track_error == ERR_POS_FIVE || motor_track_error == ERR_NEG_FIVE, "track error outside its set")
	`PDTF_ASSERT_NEVER(a_drive_limit, clk, arst_n, motor_valid && (motor_right_drive == DRIVE_MOST_NEG || motor_left_drive == DRIVE_MOST_NEG), "drive beyond saturation limit")

endmodule

bind pd_tape_follower pdtf_checker u_pdtf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.motor_valid       (motor.valid),
	.motor_ready       (motor.ready),
	.motor_right_drive (motor.right_drive),
	.motor_left_drive  (motor.left_drive),
	.motor_track_error (motor.track_error),
	.motor_is_restart  (motor.is_restart)
);
